FILE: hw/rtl/arbr_pkg.sv
package arbr_pkg;

  localparam int LEN_W    = 7;
  localparam int PERIOD_W = 24;
  localparam int CFG_W    = 16;
  localparam int CIDX_W   = 2;

  typedef enum logic [1:0] {
    KIND_OFFER = 2'd0,
    KIND_PLAY  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_FASTEST = 2'd0,
    CFG_SLOWEST = 2'd1,
    CFG_SILENCE = 2'd2
  } cfg_idx_t;

  localparam logic [15:0]      RESET_FASTEST = 16'd1600;
  localparam logic [15:0]      RESET_SLOWEST = 16'd1900;
  localparam logic [LEN_W-1:0] RESET_SILENCE = 7'd16;
  localparam logic [15:0]      RESET_PERIOD  = 16'd1750;

  typedef struct packed {
    logic [15:0]      fastest;
    logic [15:0]      slowest;
    logic [LEN_W-1:0] silence;
  } cfg_t;

  typedef struct packed {
    logic             accepted;
    logic [2:0]       slot;
    logic             play_silence;
    logic [LEN_W-1:0] play_length;
    logic [15:0]      sample_period;
    logic [2:0]       fill_level;
    logic             purging;
  } res_t;

endpackage

FILE: hw/rtl/arbr_slot_mem.sv
module arbr_slot_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [arbr_pkg::LEN_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [arbr_pkg::LEN_W-1:0] rd_data
);
  import arbr_pkg::*;

  logic [LEN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first: a slot written this cycle reads back its new length
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/arbr_ctrl.sv
module arbr_ctrl #(
  parameter int SLOT_COUNT         = 8,
  parameter int MAX_BUFFER_SAMPLES = 64,
  parameter int ADJUST_SHIFT       = 4,
  parameter int PW                 = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [1:0]                 kind,
  input  logic [arbr_pkg::LEN_W-1:0] buffer_length,
  input  arbr_pkg::cfg_t             cfg,
  input  logic [arbr_pkg::LEN_W-1:0] rd_data,
  output logic                       wr_en,
  output logic [PW-1:0]              wr_addr,
  output logic [arbr_pkg::LEN_W-1:0] wr_data,
  output logic [PW-1:0]              rd_addr,
  output arbr_pkg::res_t             res
);
  import arbr_pkg::*;

  localparam int XW = PW + 3;
  localparam logic [PW-1:0]       LAST_SLOT   = PW'(SLOT_COUNT - 1);
  localparam logic [PW:0]         SLOTS_W     = (PW+1)'(SLOT_COUNT);
  localparam logic [PW:0]         ROOM_LIMIT  = (PW+1)'(SLOT_COUNT - 2);
  localparam logic [12:0]         MAX_LEN_W   = 13'(MAX_BUFFER_SAMPLES);
  localparam logic [LEN_W-1:0]    MAX_LEN     = LEN_W'(MAX_BUFFER_SAMPLES);
  localparam logic [PERIOD_W-1:0] PERIOD_INIT = PERIOD_W'(RESET_PERIOD) << ADJUST_SHIFT;

  logic [PW-1:0]       read_slot, read_slot_next;
  logic [PW-1:0]       write_slot, write_slot_next;
  logic                purge_flag, purge_flag_next;
  logic [PERIOD_W-1:0] period, period_next;

  logic [PW:0]           diff;
  logic [PW-1:0]         fill;
  logic [PW-1:0]         fill_play;
  logic [PW-1:0]         fill_after;
  logic                  purge_tmp;
  logic [PW-1:0]         slot_v;
  logic [PERIOD_W-1:0]   fast_lim, slow_lim, dec;
  logic [PERIOD_W:0]     inc;
  logic [PERIOD_W-1:0]   sp_full;
  logic [XW-1:0]         slot_x, fill_x;
  logic [12:0]           blen_w;
  logic                  do_play, is_start;

  always_comb begin
    diff = {1'b0, write_slot} - {1'b0, read_slot};
    if (write_slot >= read_slot) begin
      fill = diff[PW-1:0];
    end else begin
      fill = PW'(diff + SLOTS_W);
    end
  end

  assign fast_lim = PERIOD_W'(cfg.fastest) << ADJUST_SHIFT;
  assign slow_lim = PERIOD_W'(cfg.slowest) << ADJUST_SHIFT;
  assign dec      = (period != '0) ? period - 1'b1 : '0;
  assign inc      = {1'b0, period} + 1'b1;
  assign blen_w   = 13'(buffer_length);

  always_comb begin
    read_slot_next  = read_slot;
    write_slot_next = write_slot;
    purge_flag_next = purge_flag;
    period_next     = period;
    wr_en           = 1'b0;
    wr_data         = (blen_w > MAX_LEN_W) ? MAX_LEN : buffer_length;
    res             = '0;
    slot_v          = '0;
    fill_after      = fill;
    fill_play       = fill;
    purge_tmp       = purge_flag;
    do_play         = 1'b0;
    is_start        = 1'b0;

    case (kind)
      KIND_OFFER: begin
        if (purge_flag && ((PW+1)'(fill) < (PW+1)'(2))) begin
          purge_tmp = 1'b0;
        end
        if (!purge_tmp && ((PW+1)'(fill) < ROOM_LIMIT)) begin
          wr_en           = step;
          slot_v          = write_slot;
          write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
          fill_after      = fill + 1'b1;
          res.accepted    = 1'b1;
          purge_flag_next = purge_tmp;
        end else begin
          purge_flag_next = 1'b1;
        end
      end
      KIND_PLAY: begin
        do_play = 1'b1;
      end
      KIND_START: begin
        do_play  = 1'b1;
        is_start = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_play) begin
      if (is_start) begin
        fill_play       = '0;
        read_slot_next  = '0;
        write_slot_next = '0;
        purge_flag_next = 1'b0;
      end
      if (fill_play != '0) begin
        slot_v          = read_slot;
        res.play_length = rd_data;
        read_slot_next  = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
        fill_after      = fill_play - 1'b1;
      end else begin
        res.play_silence = 1'b1;
        res.play_length  = cfg.silence;
        fill_after       = '0;
      end
      if ((PW+1)'(fill_after) > (PW+1)'(1)) begin
        period_next = (dec > fast_lim) ? dec : fast_lim;
      end else if (fill_after == '0) begin
        period_next = (inc < {1'b0, slow_lim}) ? inc[PERIOD_W-1:0] : slow_lim;
      end
    end

    sp_full           = period_next >> ADJUST_SHIFT;
    slot_x            = XW'(slot_v);
    fill_x            = XW'(fill_after);
    res.slot          = slot_x[2:0];
    res.fill_level    = fill_x[2:0];
    res.sample_period = sp_full[15:0];
    res.purging       = purge_flag_next;
  end

  assign wr_addr = write_slot;
  assign rd_addr = step ? read_slot_next : read_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot  <= '0;
      write_slot <= '0;
      purge_flag <= 1'b0;
      period     <= PERIOD_INIT;
    end else if (step) begin
      read_slot  <= read_slot_next;
      write_slot <= write_slot_next;
      purge_flag <= purge_flag_next;
      period     <= period_next;
    end
  end

endmodule

FILE: hw/rtl/adaptive_rate_buffer_ring_top.sv
// Each input beat goes through the input register and then the result register.
// Throughput: one item per cycle unless out_ready stalls; the slot-length memory is read
// at the next read pointer each cycle, with write-first forwarding, so plays never wait on it.
// Reset (rst, synchronous): pointers and purge flag cleared, period set to 1750
// shifted by ADJUST_SHIFT, registers to 1600/1900/16; slot lengths are not cleared.
module adaptive_rate_buffer_ring_top #(
  parameter int SLOT_COUNT         = 8,
  parameter int MAX_BUFFER_SAMPLES = 64,
  parameter int ADJUST_SHIFT       = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [arbr_pkg::LEN_W-1:0]  buffer_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [2:0]                  slot,
  output logic                        play_silence,
  output logic [arbr_pkg::LEN_W-1:0]  play_length,
  output logic [15:0]                 sample_period,
  output logic [2:0]                  fill_level,
  output logic                        purging,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [arbr_pkg::CIDX_W-1:0] cfg_index,
  input  logic [arbr_pkg::CFG_W-1:0]  cfg_data
);
  import arbr_pkg::*;

  localparam int PW = $clog2(SLOT_COUNT);

  cfg_t             cfg;
  logic             in_full;
  logic [1:0]       in_kind;
  logic [LEN_W-1:0] in_blen;
  logic             advance;
  res_t             res, res_q;

  logic             wr_en;
  logic [PW-1:0]    wr_addr, rd_addr;
  logic [LEN_W-1:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fastest <= RESET_FASTEST;
      cfg.slowest <= RESET_SLOWEST;
      cfg.silence <= RESET_SILENCE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FASTEST: cfg.fastest <= cfg_data;
        CFG_SLOWEST: cfg.slowest <= cfg_data;
        CFG_SILENCE: cfg.silence <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind <= kind;
      in_blen <= buffer_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  arbr_ctrl #(
    .SLOT_COUNT         (SLOT_COUNT),
    .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES),
    .ADJUST_SHIFT       (ADJUST_SHIFT),
    .PW                 (PW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .kind          (in_kind),
    .buffer_length (in_blen),
    .cfg           (cfg),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .res           (res)
  );

  arbr_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (PW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accepted      = res_q.accepted;
  assign slot          = res_q.slot;
  assign play_silence  = res_q.play_silence;
  assign play_length   = res_q.play_length;
  assign sample_period = res_q.sample_period;
  assign fill_level    = res_q.fill_level;
  assign purging       = res_q.purging;

`ifndef SYNTHESIS
  a_silence_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && play_silence |-> !accepted && (fill_level == 3'd0))
    else $error("silence beat with nonzero fill or accept");

  a_accept_no_purge: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !purging && !play_silence)
    else $error("accepted beat while purging");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input stalled without backpressure");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");
`endif

endmodule

FILE: sim/adaptive_rate_buffer_ring_top_tb.sv
`timescale 1ns / 100ps

module adaptive_rate_buffer_ring_top_tb;
  import arbr_pkg::*;

  localparam int SLOTS     = 8;
  localparam int MAX_LEN   = 64;
  localparam int ADJ_SHIFT = 4;
  localparam int LIMIT     = 200000;

  localparam logic [1:0]        KIND_UNKNOWN = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_UNUSED   = 2'd3;

  typedef struct {
    logic [1:0]       k;
    logic [LEN_W-1:0] len;
    bit               typed;
    res_t             want;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          kind;
  logic [LEN_W-1:0]    buffer_length;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                accepted;
  logic [2:0]          slot;
  logic                play_silence;
  logic [LEN_W-1:0]    play_length;
  logic [15:0]         sample_period;
  logic [2:0]          fill_level;
  logic                purging;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  // predictor state
  logic [2:0]          rd_ptr;
  logic [2:0]          wr_ptr;
  logic                purge_st;
  logic [PERIOD_W-1:0] frac_period;
  logic [LEN_W-1:0]    slot_len [SLOTS];
  logic [15:0]         fast_cfg;
  logic [15:0]         slow_cfg;
  logic [LEN_W-1:0]    sil_cfg;

  res_t      pending_results [$];
  step_row_t plan [$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_gap = 0;
  int        recv_stall = 0;

  adaptive_rate_buffer_ring_top #(
    .SLOT_COUNT         (SLOTS),
    .MAX_BUFFER_SAMPLES (MAX_LEN),
    .ADJUST_SHIFT       (ADJ_SHIFT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .buffer_length (buffer_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .slot          (slot),
    .play_silence  (play_silence),
    .play_length   (play_length),
    .sample_period (sample_period),
    .fill_level    (fill_level),
    .purging       (purging),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic res_t ring_step(input logic [1:0] k, input logic [LEN_W-1:0] len);
    res_t                r;
    logic [2:0]          filled;
    logic [PERIOD_W-1:0] nxt;
    logic [PERIOD_W-1:0] lim;
    r = '0;
    filled = wr_ptr - rd_ptr;
    case (k)
      KIND_OFFER: begin
        if (purge_st && filled < 2) purge_st = 1'b0;
        if (!purge_st && filled < SLOTS - 2) begin
          slot_len[wr_ptr] = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
          r.accepted = 1'b1;
          r.slot = wr_ptr;
          wr_ptr = wr_ptr + 3'd1;
        end else begin
          purge_st = 1'b1;
        end
      end
      KIND_PLAY, KIND_START: begin
        if (k == KIND_START) begin
          rd_ptr = '0;
          wr_ptr = '0;
          purge_st = 1'b0;
          filled = '0;
        end
        if (filled != 0) begin
          r.slot = rd_ptr;
          r.play_length = slot_len[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          filled = filled - 3'd1;
        end else begin
          r.play_silence = 1'b1;
          r.play_length = sil_cfg;
        end
        if (filled > 1) begin
          nxt = (frac_period == 0) ? '0 : frac_period - 1'b1;
          lim = PERIOD_W'(fast_cfg) << ADJ_SHIFT;
          frac_period = (nxt > lim) ? nxt : lim;
        end else if (filled == 0) begin
          nxt = frac_period + 1'b1;
          lim = PERIOD_W'(slow_cfg) << ADJ_SHIFT;
          frac_period = (nxt < lim) ? nxt : lim;
        end
      end
      default: ;
    endcase
    r.sample_period = 16'(frac_period >> ADJ_SHIFT);
    r.fill_level = wr_ptr - rd_ptr;
    r.purging = purge_st;
    return r;
  endfunction

  task automatic log_miss(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic chk(input string name, input int unsigned got, input int unsigned want);
    if (got != want) log_miss($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // called at a falling edge, returns at a falling edge with in_valid still high
  task automatic put_item(input logic [1:0] k, input logic [LEN_W-1:0] len,
                          input bit typed, input res_t want);
    res_t r;
    while ($urandom_range(0, 99) < send_gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    buffer_length <= len;
    do @(posedge clk); while (!in_ready);
    r = ring_step(k, len);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FASTEST: fast_cfg = data;
      CFG_SLOWEST: slow_cfg = data;
      CFG_SILENCE: sil_cfg = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall);

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {accepted, slot, play_silence, play_length, sample_period, fill_level, purging};
      if (pending_results.size() == 0) begin
        log_miss("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        chk("accepted", got.accepted, want.accepted);
        chk("slot", got.slot, want.slot);
        chk("play_silence", got.play_silence, want.play_silence);
        chk("play_length", got.play_length, want.play_length);
        chk("sample_period", got.sample_period, want.sample_period);
        chk("fill_level", got.fill_level, want.fill_level);
        chk("purging", got.purging, want.purging);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [15:0]      f;
    logic [15:0]      s;
    logic [LEN_W-1:0] l;
    logic [1:0]       k;
    logic [LEN_W-1:0] len;
    int               bias;
    int               r;

    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    buffer_length = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    rd_ptr = '0;
    wr_ptr = '0;
    purge_st = 1'b0;
    frac_period = PERIOD_W'(RESET_PERIOD) << ADJ_SHIFT;
    fast_cfg = RESET_FASTEST;
    slow_cfg = RESET_SLOWEST;
    sil_cfg = RESET_SILENCE;

    // empty ring, fill to the limit, refusal, purge drain, restart
    plan.push_back('{KIND_PLAY, 7'd0, 1'b1,
                     res_t'{1'b0, 3'd0, 1'b1, 7'd16, 16'd1750, 3'd0, 1'b0}});
    plan.push_back('{KIND_UNKNOWN, 7'd127, 1'b1,
                     res_t'{1'b0, 3'd0, 1'b0, 7'd0, 16'd1750, 3'd0, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd0, 1'b1,
                     res_t'{1'b1, 3'd0, 1'b0, 7'd0, 16'd1750, 3'd1, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd64, 1'b1,
                     res_t'{1'b1, 3'd1, 1'b0, 7'd0, 16'd1750, 3'd2, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd127, 1'b1,
                     res_t'{1'b1, 3'd2, 1'b0, 7'd0, 16'd1750, 3'd3, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd65, 1'b1,
                     res_t'{1'b1, 3'd3, 1'b0, 7'd0, 16'd1750, 3'd4, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd1, 1'b1,
                     res_t'{1'b1, 3'd4, 1'b0, 7'd0, 16'd1750, 3'd5, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd42, 1'b1,
                     res_t'{1'b1, 3'd5, 1'b0, 7'd0, 16'd1750, 3'd6, 1'b0}});
    plan.push_back('{KIND_OFFER, 7'd3, 1'b1,
                     res_t'{1'b0, 3'd0, 1'b0, 7'd0, 16'd1750, 3'd6, 1'b1}});
    plan.push_back('{KIND_PLAY, 7'd127, 1'b0, '0});
    plan.push_back('{KIND_OFFER, 7'd9, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_OFFER, 7'd10, 1'b0, '0});
    plan.push_back('{KIND_START, 7'd127, 1'b0, '0});
    plan.push_back('{KIND_OFFER, 7'd127, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_UNKNOWN, 7'd0, 1'b0, '0});
    plan.push_back('{KIND_OFFER, 7'd85, 1'b0, '0});
    plan.push_back('{KIND_PLAY, 7'd85, 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap = 23;
    recv_stall = 82;
    foreach (plan[i]) put_item(plan[i].k, plan[i].len, plan[i].typed, plan[i].want);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      while (pending_results.size() != 0) @(posedge clk);
      repeat (4) @(negedge clk);
      case (ph)
        0: begin f = 16'd1;     s = 16'd65535; l = 7'd64; end
        1: begin f = 16'd65535; s = 16'd1;     l = 7'd1;  end
        2: begin f = 16'd1740;  s = 16'd1760;  l = 7'($urandom_range(1, 64)); end
        3: begin
          f = 16'($urandom_range(1, 65535));
          s = 16'($urandom_range(1, 65535));
          l = 7'($urandom_range(1, 64));
        end
        4: begin f = 16'd1746;  s = 16'd1754;  l = 7'd64; end
        default: begin f = RESET_FASTEST; s = RESET_SLOWEST; l = RESET_SILENCE; end
      endcase
      reg_write(CFG_FASTEST, f);
      reg_write(CFG_SLOWEST, s);
      reg_write(CFG_SILENCE, CFG_W'(l));
      if (ph == 5) reg_write(CFG_UNUSED, CFG_W'($urandom));
      cfg_valid <= 1'b0;

      case (ph / 2)
        0: begin send_gap = 23; recv_stall = 82; end
        1: begin send_gap = 82; recv_stall = 23; end
        default: begin send_gap = 0; recv_stall = 0; end
      endcase

      bias = 1;
      for (int n = 0; n < 142; n++) begin
        // bursts lean toward filling, draining or balance
        if (n % 16 == 0) bias = $urandom_range(0, 2);
        r = $urandom_range(0, 99);
        if (r < 2) k = KIND_UNKNOWN;
        else if (r < 5) k = KIND_START;
        else if ($urandom_range(0, 99) < 25 + 25 * bias) k = KIND_OFFER;
        else k = KIND_PLAY;
        if (k == KIND_OFFER)
          len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                            : 7'($urandom_range(0, 64));
        else
          len = 7'($urandom_range(0, 127));
        put_item(k, len, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
